// ===== rtl/smeu_pkg.sv =====
// ---------------------------------------------------------------------------
// smeu_pkg
// shared types, opcodes and status codes of the stack machine execute unit
// ---------------------------------------------------------------------------
package smeu_pkg;

    localparam int DATA_W       = 32;
    localparam int PC_W         = 16;
    localparam int DS_DEPTH_DEF = 32;
    localparam int RS_DEPTH_DEF = 16;
    localparam int LIT_BYTES    = 4;
    localparam int BR_BYTES     = 2;

    localparam logic [4:0] OP_LIT   = 5'd0;
    localparam logic [4:0] OP_DUP   = 5'd1;
    localparam logic [4:0] OP_DROP  = 5'd2;
    localparam logic [4:0] OP_SWAP  = 5'd3;
    localparam logic [4:0] OP_OVER  = 5'd4;
    localparam logic [4:0] OP_ADD   = 5'd5;
    localparam logic [4:0] OP_SUB   = 5'd6;
    localparam logic [4:0] OP_MUL   = 5'd7;
    localparam logic [4:0] OP_DIV   = 5'd8;
    localparam logic [4:0] OP_EQ    = 5'd9;
    localparam logic [4:0] OP_LT    = 5'd10;
    localparam logic [4:0] OP_JMP   = 5'd11;
    localparam logic [4:0] OP_JZ    = 5'd12;
    localparam logic [4:0] OP_RET   = 5'd13;
    localparam logic [4:0] OP_TOR   = 5'd14;
    localparam logic [4:0] OP_FROMR = 5'd15;
    localparam logic [4:0] OP_LIT0  = 5'd16;
    localparam logic [4:0] OP_LIT1  = 5'd17;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_INVALID  = 4'd1;
    localparam logic [3:0] ST_DIVZERO  = 4'd2;
    localparam logic [3:0] ST_BOUNDS   = 4'd3;
    localparam logic [3:0] ST_DS_UNDER = 4'd4;
    localparam logic [3:0] ST_DS_OVER  = 4'd5;
    localparam logic [3:0] ST_RS_UNDER = 4'd6;
    localparam logic [3:0] ST_RS_OVER  = 4'd7;
    localparam logic [3:0] ST_HALTED   = 4'd8;

    typedef struct packed {
        logic [4:0]         operation;
        logic signed [31:0] literal_value;
        logic signed [15:0] branch_offset;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         status;
        logic [15:0]        next_pc;
        logic signed [31:0] top_value;
        logic [5:0]         stack_depth;
        logic               done_res;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic wr2;
        logic div_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_rd;
        logic is_swap;
        logic is_div;
        logic div_done;
    } t_sts;

endpackage

// ===== rtl/smeu_ram.sv =====
// ---------------------------------------------------------------------------
// smeu_ram
// generic simple dual port ram, one write port, registered read
// ---------------------------------------------------------------------------
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/smeu_div.sv =====
// ---------------------------------------------------------------------------
// smeu_div
// signed 32-bit divider, one quotient bit per cycle, truncates toward zero
// ---------------------------------------------------------------------------
module smeu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import smeu_pkg::*;

    localparam int CW = $clog2(DATA_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W:0]   r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic              r_neg, n_neg;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_neg   = r_neg;
        rem_sh  = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_dvs  = i_divisor[DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!rem_sub[DATA_W]) begin
                n_rem = rem_sub;
                n_quo = {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(DATA_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;
endmodule

// ===== rtl/smeu_dp.sv =====
// ---------------------------------------------------------------------------
// smeu_dp
// datapath: stacks, program counter, checks, alu, divider and output word
// ---------------------------------------------------------------------------
module smeu_dp #(
    parameter int DS_DEPTH = smeu_pkg::DS_DEPTH_DEF,
    parameter int RS_DEPTH = smeu_pkg::RS_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smeu_pkg::t_in_word   i_in_word,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  smeu_pkg::t_cmd       i_cmd,
    output smeu_pkg::t_sts       o_sts,
    output smeu_pkg::t_out_word  o_out_word
);
    import smeu_pkg::*;

    localparam int DAW = $clog2(DS_DEPTH);
    localparam int RAW = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
    localparam int DDW = $clog2(DS_DEPTH + 1);
    localparam int RDW = $clog2(RS_DEPTH + 1);

    logic [4:0]         r_op, n_op;
    logic [DATA_W-1:0]  r_lit, n_lit;
    logic signed [15:0] r_off, n_off;
    logic [PC_W-1:0]    r_len, n_len;
    logic [PC_W-1:0]    r_pc, n_pc;
    logic               r_halt, n_halt;
    logic [DDW-1:0]     r_dd, n_dd;
    logic [RDW-1:0]     r_rd, n_rd;
    logic [DATA_W-1:0]  r_tos, n_tos;
    logic [DATA_W-1:0]  r_nos, n_nos;
    logic [3:0]         r_st, n_st;
    logic               r_done, n_done;
    t_out_word          r_out, n_out;

    logic               ds_we, rs_we;
    logic [DAW-1:0]     ds_waddr, ds_raddr;
    logic [RAW-1:0]     rs_waddr, rs_raddr;
    logic [DATA_W-1:0]  ds_wdata, ds_q, rs_q;
    logic               div_start, div_done;
    logic [DATA_W-1:0]  div_quo;

    logic               halt_c, trunc, taken, tgt_bad, is_br, fin;
    logic               d_lt1, d_lt2, d_full, r_empty, r_full;
    logic [PC_W:0]      npc, npc_f;
    logic signed [PC_W+1:0] tgt;
    logic [3:0]         exec_st;
    logic [DATA_W-1:0]  bres;

    smeu_ram #(.WIDTH(DATA_W), .DEPTH(DS_DEPTH)) u_ds_ram (
        .i_clk  (i_clk),
        .i_we   (ds_we),
        .i_waddr(ds_waddr),
        .i_wdata(ds_wdata),
        .i_raddr(ds_raddr),
        .o_rdata(ds_q)
    );

    smeu_ram #(.WIDTH(DATA_W), .DEPTH(RS_DEPTH)) u_rs_ram (
        .i_clk  (i_clk),
        .i_we   (rs_we),
        .i_waddr(rs_waddr),
        .i_wdata(r_tos),
        .i_raddr(rs_raddr),
        .o_rdata(rs_q)
    );

    smeu_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(ds_q),
        .i_divisor (r_tos),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // checks, branch target and alu result
    always_comb begin
        halt_c  = r_halt || (r_pc >= r_len);
        is_br   = (r_op == OP_JMP) || (r_op == OP_JZ);
        if (r_op == OP_LIT) begin
            npc = {1'b0, r_pc} + (PC_W+1)'(LIT_BYTES + 1);
        end else if (is_br) begin
            npc = {1'b0, r_pc} + (PC_W+1)'(BR_BYTES + 1);
        end else begin
            npc = {1'b0, r_pc} + 1'b1;
        end
        trunc   = npc > {1'b0, r_len};
        taken   = (r_op == OP_JMP) || (r_tos == '0);
        tgt     = $signed({1'b0, npc}) + (PC_W+2)'(r_off);
        tgt_bad = (tgt < 0) || (tgt > $signed({2'b00, r_len}));
        npc_f   = (is_br && taken) ? tgt[PC_W:0] : npc;
        d_lt1   = r_dd == '0;
        d_lt2   = r_dd < DDW'(2);
        d_full  = r_dd >= DDW'(DS_DEPTH);
        r_empty = r_rd == '0;
        r_full  = r_rd >= RDW'(RS_DEPTH);

        exec_st = ST_OK;
        case (r_op)
            OP_LIT: begin
                if (trunc) exec_st = ST_INVALID;
                else if (d_full) exec_st = ST_DS_OVER;
            end
            OP_DUP: begin
                if (d_lt1) exec_st = ST_DS_UNDER;
                else if (d_full) exec_st = ST_DS_OVER;
            end
            OP_DROP: begin
                if (d_lt1) exec_st = ST_DS_UNDER;
            end
            OP_SWAP: begin
                if (d_lt2) exec_st = ST_DS_UNDER;
            end
            OP_OVER: begin
                if (d_lt2) exec_st = ST_DS_UNDER;
                else if (d_full) exec_st = ST_DS_OVER;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT: begin
                if (d_lt2) exec_st = ST_DS_UNDER;
                else if (r_op == OP_DIV && r_tos == '0) exec_st = ST_DIVZERO;
            end
            OP_JMP, OP_JZ: begin
                if (trunc) exec_st = ST_INVALID;
                else if (r_op == OP_JZ && d_lt1) exec_st = ST_DS_UNDER;
                else if (taken && tgt_bad) exec_st = ST_BOUNDS;
            end
            OP_RET: begin
                exec_st = ST_OK;
            end
            OP_TOR: begin
                if (d_lt1) exec_st = ST_DS_UNDER;
                else if (r_full) exec_st = ST_RS_OVER;
            end
            OP_FROMR: begin
                if (r_empty) exec_st = ST_RS_UNDER;
                else if (d_full) exec_st = ST_DS_OVER;
            end
            OP_LIT0, OP_LIT1: begin
                if (d_full) exec_st = ST_DS_OVER;
            end
            default: exec_st = ST_INVALID;
        endcase

        case (r_op)
            OP_ADD:  bres = ds_q + r_tos;
            OP_SUB:  bres = ds_q - r_tos;
            OP_MUL:  bres = ds_q * r_tos;
            OP_EQ:   bres = {DATA_W{ds_q == r_tos}};
            default: bres = {DATA_W{$signed(ds_q) < $signed(r_tos)}};
        endcase
    end

    assign fin = (npc_f == {1'b0, r_len}) || (r_op == OP_RET);

    always_comb begin
        n_op   = r_op;
        n_lit  = r_lit;
        n_off  = r_off;
        n_len  = r_len;
        n_pc   = r_pc;
        n_halt = r_halt;
        n_dd   = r_dd;
        n_rd   = r_rd;
        n_tos  = r_tos;
        n_nos  = r_nos;
        n_st   = r_st;
        n_done = r_done;
        n_out  = r_out;
        ds_we    = 1'b0;
        ds_waddr = DAW'(r_dd);
        ds_wdata = r_tos;
        ds_raddr = DAW'(r_dd - DDW'(2));
        rs_we    = 1'b0;
        rs_waddr = RAW'(r_rd);
        rs_raddr = RAW'(r_rd - 1'b1);
        div_start = 1'b0;
        o_sts.need_rd  = 1'b0;
        o_sts.is_swap  = r_op == OP_SWAP;
        o_sts.is_div   = r_op == OP_DIV;
        o_sts.div_done = div_done;

        if (i_cmd.load) begin
            n_op  = i_in_word.operation;
            n_lit = i_in_word.literal_value;
            n_off = i_in_word.branch_offset;
        end

        if (i_cmd.exec) begin
            n_done = 1'b0;
            if (halt_c) begin
                n_st = ST_HALTED;
            end else if (exec_st != ST_OK) begin
                n_st   = exec_st;
                n_halt = 1'b1;
            end else begin
                n_st   = ST_OK;
                n_pc   = npc_f[PC_W-1:0];
                n_done = fin;
                if (fin) n_halt = 1'b1;
                case (r_op)
                    OP_LIT, OP_LIT0, OP_LIT1, OP_DUP: begin
                        ds_we    = 1'b1;
                        ds_wdata = (r_op == OP_LIT)  ? r_lit :
                                   (r_op == OP_LIT1) ? DATA_W'(1) :
                                   (r_op == OP_LIT0) ? '0 : r_tos;
                        n_tos    = ds_wdata;
                        n_dd     = r_dd + 1'b1;
                    end
                    OP_DROP, OP_JZ, OP_TOR: begin
                        n_dd          = r_dd - 1'b1;
                        rs_we         = r_op == OP_TOR;
                        n_rd          = (r_op == OP_TOR) ? r_rd + 1'b1 : r_rd;
                        o_sts.need_rd = !d_lt2;
                    end
                    OP_SWAP, OP_OVER, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT,
                    OP_FROMR: begin
                        o_sts.need_rd = 1'b1;
                    end
                    default: begin
                        n_tos = r_tos;
                    end
                endcase
            end
        end

        if (i_cmd.step) begin
            case (r_op)
                OP_DROP, OP_JZ, OP_TOR: begin
                    n_tos = ds_q;
                end
                OP_SWAP: begin
                    ds_we    = 1'b1;
                    ds_waddr = DAW'(r_dd - DDW'(2));
                    ds_wdata = r_tos;
                    n_nos    = ds_q;
                end
                OP_OVER: begin
                    ds_we    = 1'b1;
                    ds_wdata = ds_q;
                    n_tos    = ds_q;
                    n_dd     = r_dd + 1'b1;
                end
                OP_FROMR: begin
                    ds_we    = 1'b1;
                    ds_wdata = rs_q;
                    n_tos    = rs_q;
                    n_dd     = r_dd + 1'b1;
                    n_rd     = r_rd - 1'b1;
                end
                OP_DIV: begin
                    div_start = 1'b1;
                end
                default: begin
                    ds_we    = 1'b1;
                    ds_waddr = DAW'(r_dd - DDW'(2));
                    ds_wdata = bres;
                    n_tos    = bres;
                    n_dd     = r_dd - 1'b1;
                end
            endcase
        end

        if (i_cmd.wr2) begin
            ds_we    = 1'b1;
            ds_waddr = DAW'(r_dd - 1'b1);
            ds_wdata = r_nos;
            n_tos    = r_nos;
        end

        if (i_cmd.div_fin) begin
            ds_we    = 1'b1;
            ds_waddr = DAW'(r_dd - DDW'(2));
            ds_wdata = div_quo;
            n_tos    = div_quo;
            n_dd     = r_dd - 1'b1;
        end

        if (i_cmd.out_load) begin
            n_out.status      = r_st;
            n_out.next_pc     = r_pc;
            n_out.top_value   = (r_dd == '0) ? '0 : r_tos;
            n_out.stack_depth = 6'(r_dd);
            n_out.done_res    = r_done;
        end

        if (i_cfg_we) begin
            n_len  = i_cfg_wdata;
            n_halt = 1'b0;
            n_pc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= PC_W'(1);
            r_pc   <= '0;
            r_halt <= 1'b0;
            r_dd   <= '0;
            r_rd   <= '0;
        end else begin
            r_len  <= n_len;
            r_pc   <= n_pc;
            r_halt <= n_halt;
            r_dd   <= n_dd;
            r_rd   <= n_rd;
        end
        r_op   <= n_op;
        r_lit  <= n_lit;
        r_off  <= n_off;
        r_tos  <= n_tos;
        r_nos  <= n_nos;
        r_st   <= n_st;
        r_done <= n_done;
        r_out  <= n_out;
    end

    assign o_out_word = r_out;

    a_ds_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dd <= DDW'(DS_DEPTH))
        else $error("data stack depth beyond capacity");

    a_rs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= RDW'(RS_DEPTH))
        else $error("return stack depth beyond capacity");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (!r_halt && r_pc == '0))
        else $error("length write did not restart the program");
endmodule

// ===== rtl/smeu_ctrl.sv =====
// ---------------------------------------------------------------------------
// smeu_ctrl
// sequencer: accept, execute, stack read, second write, divide, output
// ---------------------------------------------------------------------------
module smeu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    input  smeu_pkg::t_sts  i_sts,
    output smeu_pkg::t_cmd  o_cmd
);
    import smeu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_READ = 6'b000100,
        S_WR2  = 6'b001000,
        S_DIVW = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov, n_ov;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_ov    = r_ov && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_rd ? S_READ : S_OUT;
            end
            S_READ: begin
                o_cmd.step = 1'b1;
                if (i_sts.is_swap) n_state = S_WR2;
                else if (i_sts.is_div) n_state = S_DIVW;
                else n_state = S_OUT;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state   = S_OUT;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ov           = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ov;

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC)
        else $error("accepted word did not start execution");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> r_ov)
        else $error("pending result dropped");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && i_sts.is_div) |=> r_state == S_DIVW)
        else $error("divide not awaited");
endmodule

// ===== rtl/stack_machine_execute_unit_core.sv =====
// each word passes accept, execute and output; push, jmp, ret and pops without reload take
// only that path, ops that read a second stack entry add a stack read, swap also a second
// write and div a divider wait (the divider retires one quotient bit per cycle)
// one word at a time, the next word is taken once the result is lodged
// synchronous active-low reset empties both stacks, clears pc and halt, length 1
// ---------------------------------------------------------------------------
// stack_machine_execute_unit_core
// forth style stack machine execute unit, controller plus datapath
// ---------------------------------------------------------------------------
module stack_machine_execute_unit_core #(
    parameter int DS_DEPTH = smeu_pkg::DS_DEPTH_DEF,
    parameter int RS_DEPTH = smeu_pkg::RS_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  smeu_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output smeu_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata
);
    import smeu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    smeu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smeu_dp #(.DS_DEPTH(DS_DEPTH), .RS_DEPTH(RS_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_word (o_out_word)
    );
endmodule
